// ===== rtl/dep_pkg.sv =====
// ----------------------------------------------------------------------------
// dep_pkg
// Shared constants, codes and controller/datapath interface types for the
// double-ended priority queue.
// ----------------------------------------------------------------------------
package dep_pkg;

    localparam int DEP_CAPACITY = 1024;
    localparam int VALUE_W      = 32;
    localparam int ACTION_W     = 2;
    localparam int STATUS_W     = 2;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_INSERT     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_MIN = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY_MAX  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic                load_item;    // latch the incoming value
        logic                ins_start;    // set up the insert walk from the tail
        logic                shift;        // move one entry up a slot
        logic                place;        // write the new value and grow
        logic                pop;          // drop the minimum
        logic                res_set;      // capture the result
        logic                res_from_ram; // result value is the read data
        logic [STATUS_W-1:0] res_status;
        logic                out_load;     // move the result to the output register
    } t_dep_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic greater;   // entry under the walk pointer is above the new value
        logic out_free;  // output register can take a result this cycle
    } t_dep_sts;

endpackage

// ===== rtl/double_ended_priority_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Bounded sorted multiset of signed values with insert, remove-min and
// query-max; one result beat per input beat.
// ----------------------------------------------------------------------------
//  channel | valid    | stall    | payload
//  --------+----------+----------+-------------------------------
//  input   | i_valid  | o_stall  | i_action, i_value
//  output  | o_valid  | i_stall  | o_result_value, o_status
//
//  remove-min, unused action, empty or full cases: result set on acceptance, then ST_DONE
//  query-max: one registered RAM read of the tail entry, then ST_QRY and ST_DONE
//  insert: the store is walked down from the tail one RAM read/compare/write
//  per cycle, shifting up a slot each stored value greater than the new one
//  reset empties the store at once (count cleared, no clearing pass)
//  a stalled output holds the finished result; the next beat is taken meanwhile
// ----------------------------------------------------------------------------
module double_ended_priority_queue #(
    parameter int CAPACITY = dep_pkg::DEP_CAPACITY
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [dep_pkg::ACTION_W-1:0]       i_action,
    input  logic signed [dep_pkg::VALUE_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [dep_pkg::VALUE_W-1:0] o_result_value,
    output logic [dep_pkg::STATUS_W-1:0]       o_status
);

    import dep_pkg::*;

    t_dep_cmd cmd;
    t_dep_sts sts;

    dep_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    dep_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_value        (i_value),
        .i_stall        (i_stall),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

`ifndef ASSERT_OFF
    // a new value never goes into a full store
    a_no_place_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.place |-> !sts.full)
        else $error("insert placed into full store");

    // an accepted beat keeps the input side busy until its result is loaded into the output register
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again before result was handed over");

    // the output register is only overwritten when free
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a stalled output beat");

    // one write source at a time on the store
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.shift && cmd.place))
        else $error("shift and place in the same cycle");
`endif

endmodule

// ===== rtl/dep_ram.sv =====
// ----------------------------------------------------------------------------
// dep_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dep_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dep_datapath.sv =====
// ----------------------------------------------------------------------------
// dep_datapath
// Sorted store in RAM (ascending, last entry at the tail pointer), entry
// count, insert walk pointer, result and output registers.
// ----------------------------------------------------------------------------
module dep_datapath #(
    parameter int CAPACITY = dep_pkg::DEP_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dep_pkg::t_dep_cmd                 i_cmd,
    input  logic signed [dep_pkg::VALUE_W-1:0] i_value,
    input  logic                              i_stall,
    output dep_pkg::t_dep_sts                 o_sts,
    output logic                              o_valid,
    output logic signed [dep_pkg::VALUE_W-1:0] o_result_value,
    output logic [dep_pkg::STATUS_W-1:0]      o_status
);

    import dep_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [AW-1:0]              r_tail, n_tail;
    logic [CW-1:0]              r_count, n_count;
    logic [AW-1:0]              r_p;
    logic [CW-1:0]              r_rem;
    logic signed [VALUE_W-1:0]  r_key;
    logic signed [VALUE_W-1:0]  r_res_value;
    logic [STATUS_W-1:0]        r_res_status;
    logic                       r_out_valid;
    logic signed [VALUE_W-1:0]  r_out_value;
    logic [STATUS_W-1:0]        r_out_status;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [AW-1:0]              ram_raddr;
    logic [VALUE_W-1:0]         ram_wdata;
    logic [VALUE_W-1:0]         ram_rdata;
    logic [AW-1:0]              p_dec;

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        if (a == AW'(CAPACITY - 1)) r = '0;
        else                        r = a + AW'(1);
        return r;
    endfunction

    function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        if (a == '0) r = AW'(CAPACITY - 1);
        else         r = a - AW'(1);
        return r;
    endfunction

    assign p_dec     = addr_dec(r_p);
    assign ram_we    = i_cmd.shift | i_cmd.place;
    assign ram_waddr = addr_inc(r_p);
    assign ram_wdata = i_cmd.shift ? ram_rdata : r_key;
    // while shifting, fetch the next lower entry; otherwise keep the tail ready
    assign ram_raddr = i_cmd.shift ? p_dec : r_tail;

    dep_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_tail  = r_tail;
        n_count = r_count;
        if (i_cmd.place) begin
            n_tail  = addr_inc(r_tail);
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail      <= AW'(CAPACITY - 1);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_tail  <= n_tail;
            r_count <= n_count;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_key <= i_value;
        end
        if (i_cmd.ins_start) begin
            r_p   <= r_tail;
            r_rem <= r_count;
        end else if (i_cmd.shift) begin
            r_p   <= p_dec;
            r_rem <= r_rem - CW'(1);
        end
        if (i_cmd.res_set) begin
            r_res_value  <= i_cmd.res_from_ram ? $signed(ram_rdata) : '0;
            r_res_status <= i_cmd.res_status;
        end
        if (i_cmd.out_load) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end
    end

    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count == CW'(CAPACITY));
    assign o_sts.greater  = (r_rem != '0) && ($signed(ram_rdata) > r_key);
    assign o_sts.out_free = !r_out_valid || !i_stall;

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;

endmodule

// ===== rtl/dep_ctrl.sv =====
// ----------------------------------------------------------------------------
// dep_ctrl
// Sequencer: decodes an accepted item, runs the insert walk over the store
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module dep_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [dep_pkg::ACTION_W-1:0]  i_action,
    input  dep_pkg::t_dep_sts             i_sts,
    output dep_pkg::t_dep_cmd             o_cmd,
    output logic                          o_stall
);

    import dep_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_INS  = 4'b0010,
        ST_QRY  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state   r_state, n_state;
    t_dep_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    cmd.load_item = 1'b1;
                    unique case (i_action)
                        ACT_INSERT: begin
                            if (i_sts.full) begin
                                cmd.res_set    = 1'b1;
                                cmd.res_status = STS_FULL;
                                n_state        = ST_DONE;
                            end else begin
                                cmd.ins_start = 1'b1;
                                n_state       = ST_INS;
                            end
                        end
                        ACT_REMOVE_MIN: begin
                            cmd.res_set = 1'b1;
                            if (i_sts.empty) begin
                                cmd.res_status = STS_EMPTY;
                            end else begin
                                cmd.pop        = 1'b1;
                                cmd.res_status = STS_OK;
                            end
                            n_state = ST_DONE;
                        end
                        ACT_QUERY_MAX: begin
                            if (i_sts.empty) begin
                                cmd.res_set    = 1'b1;
                                cmd.res_status = STS_EMPTY;
                                n_state        = ST_DONE;
                            end else begin
                                // tail entry is being read this cycle
                                n_state = ST_QRY;
                            end
                        end
                        default: begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = STS_OK;
                            n_state        = ST_DONE;
                        end
                    endcase
                end
            end
            ST_INS: begin
                if (i_sts.greater) begin
                    cmd.shift = 1'b1;
                end else begin
                    cmd.place      = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STS_OK;
                    n_state        = ST_DONE;
                end
            end
            ST_QRY: begin
                cmd.res_set      = 1'b1;
                cmd.res_from_ram = 1'b1;
                cmd.res_status   = STS_OK;
                n_state          = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != ST_IDLE);

endmodule

// ===== tb/dep_result_check.sv =====
// ----------------------------------------------------------------------------
// dep_result_check
// Watches both channels of the double-ended priority queue, keeps its own
// sorted copy of the held values, predicts the result of every accepted
// input beat and compares each accepted output beat with the oldest
// prediction. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dep_result_check #(
    parameter int CAPACITY = dep_pkg::DEP_CAPACITY
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [dep_pkg::ACTION_W-1:0]       i_in_action,
    input  logic signed [dep_pkg::VALUE_W-1:0] i_in_value,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic signed [dep_pkg::VALUE_W-1:0] i_out_result_value,
    input  logic [dep_pkg::STATUS_W-1:0]       i_out_status,
    output int                                 o_mismatch_count,
    output int                                 o_results_owed
);
    import dep_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [STATUS_W-1:0]       status;
    } t_dep_result;

    // ascending, duplicates kept
    logic signed [VALUE_W-1:0] held_values[$];
    t_dep_result               expected_results[$];

    function automatic t_dep_result apply_action(
        input logic [ACTION_W-1:0]       action,
        input logic signed [VALUE_W-1:0] value
    );
        t_dep_result res;
        int          pos;
        res.value  = '0;
        res.status = STS_OK;
        case (action)
            ACT_INSERT: begin
                if (held_values.size() >= CAPACITY) begin
                    res.status = STS_FULL;
                end else begin
                    // new value lands after every value that is not greater
                    pos = held_values.size();
                    while (pos > 0 && held_values[pos-1] > value)
                        pos--;
                    held_values.insert(pos, value);
                end
            end
            ACT_REMOVE_MIN: begin
                if (held_values.size() == 0)
                    res.status = STS_EMPTY;
                else
                    void'(held_values.pop_front());
            end
            ACT_QUERY_MAX: begin
                if (held_values.size() == 0)
                    res.status = STS_EMPTY;
                else
                    res.value = held_values[held_values.size()-1];
            end
            default: begin
                // unused code: no effect, plain ok result
            end
        endcase
        return res;
    endfunction

    // append a prediction behind the ones still owed
    function automatic void queue_expected(input t_dep_result res);
        expected_results.insert(expected_results.size(), res);
    endfunction

    task automatic note_mismatch(input string what, input t_dep_result want,
                                 input t_dep_result got);
        if (o_mismatch_count < REPORT_LIMIT)
            $display("%0t ns: %s: expected value %0d status %0d, got value %0d status %0d",
                     $time, what, want.value, want.status, got.value, got.status);
        o_mismatch_count = o_mismatch_count + 1;
    endtask

    always @(posedge i_clk) begin : score_beats
        t_dep_result want;
        t_dep_result got;
        if (!i_rst_n) begin
            held_values.delete();
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.value  = i_out_result_value;
                got.status = i_out_status;
                if (expected_results.size() == 0) begin
                    want = '0;
                    note_mismatch("result beat with nothing pending", want, got);
                end else begin
                    want = expected_results.pop_front();
                    if (want !== got)
                        note_mismatch("result beat differs", want, got);
                end
            end
            if (i_in_valid && !i_in_stall)
                queue_expected(apply_action(i_in_action, i_in_value));
        end
        o_results_owed <= expected_results.size();
    end

endmodule

// ===== tb/double_ended_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// double_ended_priority_queue_tb
// Drives insert, remove-min, query-max and unused-code beats into the queue:
// a directed opening over the value extremes and empty cases, then random
// segments of varying action mix, the insert-heavy ones growing the store so
// that long insert walks occur. Both channels idle in random bursts. Checking
// is done by dep_result_check; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module double_ended_priority_queue_tb;
    import dep_pkg::*;

    localparam logic [ACTION_W-1:0]       ACT_UNUSED   = 2'd3;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN    = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MAX    = ~VALUE_MIN;
    localparam int                        QUIET_LIMIT  = 5000;
    localparam int                        DRAIN_CYCLES = 40;
    localparam int                        SEGMENTS     = 15;
    localparam int                        SEG_BEATS    = 40;

    logic                        i_clk    = 1'b0;
    logic                        i_rst_n  = 1'b0;
    logic                        i_valid  = 1'b0;
    logic [ACTION_W-1:0]         i_action = ACT_INSERT;
    logic signed [VALUE_W-1:0]   i_value  = '0;
    logic                        i_stall  = 1'b0;
    logic                        o_stall;
    logic                        o_valid;
    logic signed [VALUE_W-1:0]   o_result_value;
    logic [STATUS_W-1:0]         o_status;

    int mismatch_count;
    int results_owed;
    bit idling_on   = 1'b0;
    int stall_left  = 0;
    int quiet_cycles = 0;

    always #10 i_clk = ~i_clk;

    double_ended_priority_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

    dep_result_check u_result_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_in_action        (i_action),
        .i_in_value         (i_value),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_out_result_value (o_result_value),
        .i_out_status       (o_status),
        .o_mismatch_count   (mismatch_count),
        .o_results_owed     (results_owed)
    );

    // output back-pressure in random bursts while idling is on
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // no beat accepted on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // returns at the edge that accepted the beat
    task automatic send_beat(input logic [ACTION_W-1:0] action,
                             input logic signed [VALUE_W-1:0] value);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= action;
        i_value  <= value;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return VALUE_MIN;
                    1:       return VALUE_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            // narrow pool so duplicates are common
            1, 2:    return $urandom_range(0, 16) - 8;
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        int                  roll;
        int                  mode;
        int                  ins_cut;
        int                  rem_cut;
        logic [ACTION_W-1:0] action;

        repeat (7) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        idling_on <= 1'b1;

        // empty store and unused code
        send_beat(ACT_QUERY_MAX, pick_value());
        send_beat(ACT_REMOVE_MIN, pick_value());
        send_beat(ACT_UNUSED, VALUE_MAX);
        // extremes and duplicates
        send_beat(ACT_INSERT, '0);
        send_beat(ACT_INSERT, VALUE_MIN);
        send_beat(ACT_INSERT, VALUE_MAX);
        send_beat(ACT_INSERT, '1);
        send_beat(ACT_INSERT, 1);
        send_beat(ACT_INSERT, VALUE_MAX);
        send_beat(ACT_INSERT, VALUE_MIN);
        send_beat(ACT_QUERY_MAX, pick_value());
        send_beat(ACT_UNUSED, VALUE_MIN);
        // drain past empty
        repeat (8) send_beat(ACT_REMOVE_MIN, pick_value());
        send_beat(ACT_QUERY_MAX, pick_value());

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            idling_on <= (seg < SEGMENTS - 3) && ($urandom_range(0, 2) != 0);
            mode = $urandom_range(0, 2);
            case (mode)
                0:       begin ins_cut = 40; rem_cut = 70; end
                1:       begin ins_cut = 65; rem_cut = 80; end
                default: begin ins_cut = 25; rem_cut = 75; end
            endcase
            repeat (SEG_BEATS) begin
                roll = $urandom_range(0, 99);
                if (roll < ins_cut)
                    action = ACT_INSERT;
                else if (roll < rem_cut)
                    action = ACT_REMOVE_MIN;
                else if (roll < 97)
                    action = ACT_QUERY_MAX;
                else
                    action = ACT_UNUSED;
                send_beat(action, pick_value());
            end
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (results_owed != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dep_pkg.sv
rtl/dep_ram.sv
rtl/dep_datapath.sv
rtl/dep_ctrl.sv
rtl/double_ended_priority_queue.sv
tb/dep_result_check.sv
tb/double_ended_priority_queue_tb.sv
